[rtl/deque_with_prime_filter_unit_macros.svh]
// Assertion macros used by the datapath.
`ifndef DEQUE_WITH_PRIME_FILTER_UNIT_MACROS_SVH
`define DEQUE_WITH_PRIME_FILTER_UNIT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define DPF_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define DPF_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/dpf_pkg.sv]
package dpf_pkg;

  localparam int DEPTH    = 16;
  localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int LEFT_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT    = 3'd0,
    CMD_PUSH_BACK     = 3'd1,
    CMD_POP_FRONT     = 3'd2,
    CMD_POP_BACK      = 3'd3,
    CMD_REMOVE_PRIMES = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RD_FRONT,
    RD_BACK,
    RD_WALK
  } rd_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_F_READ,
    S_F_START,
    S_F_WAIT,
    S_F_DONE
  } ctl_state_t;

  typedef enum logic [2:0] {
    P_IDLE,
    P_CHECK,
    P_DIV,
    P_NEXT,
    P_DONE
  } prime_state_t;

  typedef struct packed {
    logic    take;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    exec;
    logic    filt_init;
    logic    filt_keep;
    logic    filt_adv;
    logic    filt_end;
    logic    prime_start;
  } dpf_ctl_t;

  typedef struct packed {
    logic in_valid;
    cmd_t in_cmd;
    cmd_t cmd;
    logic empty;
    logic walk_last;
    logic prime_done;
    logic is_prime;
    logic out_busy;
  } dpf_sts_t;

  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return PTR_W'(s);
  endfunction

endpackage

[rtl/dpf_cmd_if.sv]
interface dpf_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [dpf_pkg::CMD_W-1:0]    command;
  logic signed [dpf_pkg::DATA_W-1:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

[rtl/dpf_rsp_if.sv]
interface dpf_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [dpf_pkg::STATUS_W-1:0]      status;
  logic signed [dpf_pkg::DATA_W-1:0] popped_value;
  logic [dpf_pkg::LEFT_W-1:0]        entries_left;

  modport source (output valid, status, popped_value, entries_left, input ready);
  modport sink   (input valid, status, popped_value, entries_left, output ready);
endinterface

[rtl/deque_with_prime_filter_unit.sv]
// Channel  Role    Word
// cmd_ch   sink    command (3 bits), value (32 bits signed)
// rsp_ch   source  status (2 bits), popped_value (32 bits signed), entries_left (5 bits)
//
// Push, pop and unused codes: the command is registered together with a read of
//   the entry store's registered read port, and the result word is then registered.
// Remove primes: each entry is read and tested in turn; values below 2 end the test
//   at once, else each trial divisor up to the square root is tried by the
//   one-bit-per-cycle remainder unit.
// Reset (rst, synchronous) clears front pointer, count and control; the store
//   needs no clearing pass.
// A new command is accepted while a result word waits; a finished result holds
//   until the output register frees.
module deque_with_prime_filter_unit (
  input  logic      clk,
  input  logic      rst,
  dpf_cmd_if.sink   cmd_ch,
  dpf_rsp_if.source rsp_ch
);
  import dpf_pkg::*;

  dpf_ctl_t ctl;
  dpf_sts_t sts;

  dpf_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .ctl (ctl)
  );

  dpf_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sts    (sts),
    .cmd_ch (cmd_ch),
    .rsp_ch (rsp_ch)
  );

endmodule

[rtl/dpf_prime_test.sv]
module dpf_prime_test (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [dpf_pkg::DATA_W-1:0] value,
  output logic                       done,
  output logic                       is_prime
);
  import dpf_pkg::*;

  localparam int ROOT_W = DATA_W / 2;
  localparam int SQ_W   = DATA_W + 1;
  localparam int REM_W  = ROOT_W + 1;
  localparam int BIT_W  = $clog2(DATA_W);

  prime_state_t      state;
  prime_state_t      state_next;
  logic [DATA_W-1:0] raw;
  logic [DATA_W-1:0] dvd;
  logic [ROOT_W-1:0] d;
  logic [SQ_W-1:0]   sq;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_sh;
  logic [BIT_W-1:0]  bit_cnt;
  logic              prime_r;
  logic              too_small;
  logic              sq_over;

  assign too_small = value[DATA_W-1] || (value < DATA_W'(2));
  assign sq_over   = sq > SQ_W'(raw);
  assign rem_sh    = {rem[ROOT_W-1:0], dvd[DATA_W-1]};

  always_comb begin
    state_next = state;
    unique case (state)
      P_IDLE:  if (start) state_next = too_small ? P_DONE : P_CHECK;
      P_CHECK: state_next = sq_over ? P_DONE : P_DIV;
      P_DIV:   if (bit_cnt == BIT_W'(DATA_W - 1)) state_next = P_NEXT;
      P_NEXT:  state_next = (rem == '0) ? P_DONE : P_CHECK;
      P_DONE:  state_next = P_IDLE;
      default: state_next = P_IDLE;
    endcase
  end

  always_comb begin
    done     = (state == P_DONE);
    is_prime = prime_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      P_IDLE: begin
        if (start) begin
          raw     <= value;
          d       <= ROOT_W'(2);
          sq      <= SQ_W'(4);
          prime_r <= 1'b0;
        end
      end
      P_CHECK: begin
        if (sq_over) begin
          prime_r <= 1'b1;
        end else begin
          dvd     <= raw;
          rem     <= '0;
          bit_cnt <= '0;
        end
      end
      P_DIV: begin
        rem     <= (rem_sh >= REM_W'(d)) ? rem_sh - REM_W'(d) : rem_sh;
        dvd     <= {dvd[DATA_W-2:0], 1'b0};
        bit_cnt <= bit_cnt + BIT_W'(1);
      end
      P_NEXT: begin
        if (rem != '0) begin
          sq <= sq + SQ_W'({d, 1'b1});
          d  <= d + ROOT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/dpf_datapath.sv]
`include "deque_with_prime_filter_unit_macros.svh"

module dpf_datapath (
  input  logic              clk,
  input  logic              rst,
  input  dpf_pkg::dpf_ctl_t ctl,
  output dpf_pkg::dpf_sts_t sts,
  dpf_cmd_if.sink           cmd_ch,
  dpf_rsp_if.source         rsp_ch
);
  import dpf_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata;
  logic [PTR_W-1:0]  rd_addr;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;

  cmd_t              cmd_r;
  logic [DATA_W-1:0] value_r;
  logic [PTR_W-1:0]  front;
  logic [PTR_W-1:0]  front_next;
  logic [PTR_W-1:0]  front_dec;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  count_m1;
  logic [CNT_W-1:0]  walk_idx;
  logic [CNT_W-1:0]  kept;
  logic              empty;
  logic              full;

  status_t           res_status;
  logic [DATA_W-1:0] res_popped;
  logic              push_wr;
  logic [PTR_W-1:0]  push_addr;

  logic              out_valid;
  logic              out_busy;
  logic              prime_done;
  logic              prime_flag;

  assign empty     = (count == '0);
  assign full      = (count == CNT_W'(DEPTH));
  assign count_m1  = count - CNT_W'(1);
  assign front_dec = (front == '0) ? PTR_W'(DEPTH - 1) : front - PTR_W'(1);
  assign out_busy  = out_valid && !rsp_ch.ready;

  assign cmd_ch.ready = ctl.take;

  always_comb begin
    sts.in_valid   = cmd_ch.valid;
    sts.in_cmd     = cmd_t'(cmd_ch.command);
    sts.cmd        = cmd_r;
    sts.empty      = empty;
    sts.walk_last  = (walk_idx == count_m1);
    sts.prime_done = prime_done;
    sts.is_prime   = prime_flag;
    sts.out_busy   = out_busy;
  end

  always_comb begin
    res_status = ST_DONE;
    res_popped = '0;
    front_next = front;
    count_next = count;
    push_wr    = 1'b0;
    push_addr  = front_dec;
    unique case (cmd_r)
      CMD_PUSH_FRONT: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          push_wr    = 1'b1;
          push_addr  = front_dec;
          front_next = front_dec;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          push_wr    = 1'b1;
          push_addr  = ring_add(front, count);
          count_next = count + CNT_W'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_popped = rdata;
          front_next = ring_add(front, CNT_W'(1));
          count_next = count_m1;
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_popped = rdata;
          count_next = count_m1;
        end
      end
      CMD_REMOVE_PRIMES: begin
        if (empty) res_status = ST_EMPTY;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    wr_en   = (ctl.exec && push_wr) || ctl.filt_keep;
    wr_addr = ctl.filt_keep ? ring_add(front, kept) : push_addr;
    wr_data = ctl.filt_keep ? rdata : value_r;
  end

  always_comb begin
    unique case (ctl.rd_sel)
      RD_FRONT: rd_addr = front;
      RD_BACK:  rd_addr = ring_add(front, count_m1);
      RD_WALK:  rd_addr = ring_add(front, walk_idx);
      default:  rd_addr = front;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (ctl.rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.take && cmd_ch.valid) begin
      cmd_r   <= cmd_t'(cmd_ch.command);
      value_r <= cmd_ch.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      count    <= '0;
      walk_idx <= '0;
      kept     <= '0;
    end else begin
      if (ctl.exec) begin
        front <= front_next;
        count <= count_next;
      end
      if (ctl.filt_init) begin
        walk_idx <= '0;
        kept     <= '0;
      end else begin
        if (ctl.filt_adv) walk_idx <= walk_idx + CNT_W'(1);
        if (ctl.filt_keep) kept <= kept + CNT_W'(1);
      end
      if (ctl.filt_end) count <= kept;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.exec || ctl.filt_end) begin
      out_valid <= 1'b1;
    end else if (rsp_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      rsp_ch.status       <= res_status;
      rsp_ch.popped_value <= res_popped;
      rsp_ch.entries_left <= LEFT_W'(count_next);
    end else if (ctl.filt_end) begin
      rsp_ch.status       <= ST_DONE;
      rsp_ch.popped_value <= '0;
      rsp_ch.entries_left <= LEFT_W'(kept);
    end
  end

  assign rsp_ch.valid = out_valid;

  dpf_prime_test u_prime (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.prime_start),
    .value    (rdata),
    .done     (prime_done),
    .is_prime (prime_flag)
  );

  `DPF_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(DEPTH), "entry count above depth")
  `DPF_ASSERT_IMPLIES(a_no_overwrite, ctl.exec || ctl.filt_end, !out_busy, "result word lost")
  `DPF_ASSERT_ALWAYS(a_kept_bound, kept <= walk_idx, "filter write ahead of read")

endmodule

[rtl/dpf_ctrl.sv]
module dpf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  dpf_pkg::dpf_sts_t sts,
  output dpf_pkg::dpf_ctl_t ctl
);
  import dpf_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;
  logic       filter_go;

  assign filter_go = (sts.cmd == CMD_REMOVE_PRIMES) && !sts.empty;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (sts.in_valid) state_next = S_EXEC;
      S_EXEC:    if (!sts.out_busy) state_next = filter_go ? S_F_READ : S_IDLE;
      S_F_READ:  state_next = S_F_START;
      S_F_START: state_next = S_F_WAIT;
      S_F_WAIT:  if (sts.prime_done) state_next = sts.walk_last ? S_F_DONE : S_F_READ;
      S_F_DONE:  if (!sts.out_busy) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.rd_sel = RD_FRONT;
    unique case (state)
      S_IDLE: begin
        ctl.take   = 1'b1;
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = (sts.in_cmd == CMD_POP_BACK) ? RD_BACK : RD_FRONT;
      end
      S_EXEC: begin
        if (!sts.out_busy) begin
          ctl.filt_init = filter_go;
          ctl.exec      = !filter_go;
        end
      end
      S_F_READ: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = RD_WALK;
      end
      S_F_START: ctl.prime_start = 1'b1;
      S_F_WAIT: begin
        if (sts.prime_done) begin
          ctl.filt_keep = !sts.is_prime;
          ctl.filt_adv  = 1'b1;
        end
      end
      S_F_DONE: ctl.filt_end = !sts.out_busy;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
